// ----- rtl/core/nlbm_pkg.sv -----
// Package with the widths, address codes and shared types of the bank mapper.
package nlbm_pkg;

	// Program ROM size as a power of two, and the width of the offset field.
	localparam int ROM_ADDR_BITS = 17;
	localparam int OFF_W         = 17;
	localparam int ADDR_W        = 16;
	localparam int DATA_W        = 8;
	localparam int NUM_BANKS     = 8;
	localparam int BANK_IDX_W    = $clog2(NUM_BANKS);
	localparam int BANK_W        = 6;

	// Offsets wrap to the ROM size first, then to the output field.
	localparam logic [OFF_W-1:0] ROM_MASK =
		OFF_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

	// Access kinds.
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Top address nibble codes after the 0xF003 decode mask.
	localparam logic [3:0] TOP_MIRROR_A = 4'h8;
	localparam logic [3:0] TOP_MIRROR_B = 4'h9;
	localparam logic [3:0] TOP_BANK_LO  = 4'hB;
	localparam logic [3:0] TOP_BANK_HI  = 4'hE;

	// Fixed banks for the upper read ranges.
	localparam logic [3:0] FIXED8K_BANK  = 4'hD;
	localparam logic [2:0] FIXED16K_BANK = 3'd7;

	// Read ranges, by address.
	localparam logic [ADDR_W-1:0] ROM_BASE    = 16'h6000;
	localparam logic [ADDR_W-1:0] FIXED8K_LO  = 16'hA000;
	localparam logic [ADDR_W-1:0] FIXED16K_LO = 16'hC000;

	// Register write request passed to the bank register file.
	typedef struct packed {
		logic              en;
		logic [3:0]        top;
		logic [1:0]        sel;
		logic [DATA_W-1:0] data;
	} wr_req_t;

endpackage

// ----- rtl/core/nlbm_if.sv -----
// Valid/ready channel interfaces for bus accesses and translation results.
interface nlbm_req_if;
	import nlbm_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] bus_addr;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output req_type, output bus_addr, output write_data,
		input ready);
	modport sink (input valid, input req_type, input bus_addr, input write_data,
		output ready);
endinterface

interface nlbm_rsp_if;
	import nlbm_pkg::*;

	logic             valid;
	logic             ready;
	logic             rom_hit;
	logic [OFF_W-1:0] rom_offset;
	logic             mirror_select;

	modport source (output valid, output rom_hit, output rom_offset,
		output mirror_select, input ready);
	modport sink (input valid, input rom_hit, input rom_offset,
		input mirror_select, output ready);
endinterface

// ----- rtl/core/nlbm_bank_regs.sv -----
// Bank register file and mirroring bit, with nibble-wise write decode.
module nlbm_bank_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nlbm_pkg::wr_req_t            wr,
	input  logic [nlbm_pkg::BANK_IDX_W-1:0] rd_idx,
	output logic [nlbm_pkg::BANK_W-1:0]  rd_bank,
	output logic                         mirror_next
);
	import nlbm_pkg::*;

	logic [DATA_W-1:0]     bank_q [NUM_BANKS];
	logic                  mirror_q;
	logic                  mirror_wr;
	logic                  bank_wr;
	logic [BANK_IDX_W-1:0] wr_idx;
	logic [3:0]            top_off;

	// Decode the masked write address into a mirror or a bank nibble write.
	always_comb begin
		mirror_wr = wr.en && (wr.top == TOP_MIRROR_A || wr.top == TOP_MIRROR_B);
		bank_wr   = wr.en && (wr.top >= TOP_BANK_LO) && (wr.top <= TOP_BANK_HI);
		top_off   = wr.top - TOP_BANK_LO;
		wr_idx    = {top_off[1:0], wr.sel[1]};
	end

	// The mirroring bit seen by this access already includes its own write.
	assign mirror_next = mirror_wr ? wr.data[0] : mirror_q;

	// Only bits 5:0 of a bank register take part in the window mapping.
	assign rd_bank = bank_q[rd_idx][BANK_W-1:0];

	// Register updates; an even address loads the low nibble, odd the high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			for (int i = 0; i < NUM_BANKS; i++) begin
				bank_q[i] <= '0;
			end
		end else begin
			mirror_q <= mirror_next;
			if (bank_wr) begin
				if (!wr.sel[0]) begin
					bank_q[wr_idx][3:0] <= wr.data[3:0];
				end else begin
					bank_q[wr_idx][7:4] <= wr.data[3:0];
				end
			end
		end
	end

endmodule

// ----- rtl/core/nibble_loaded_bank_mapper.sv -----
// Top level of the nibble-loaded bank mapper with 2 KB program windows.
//
// One channel, req, carries CPU bus accesses (req_type, bus_addr, write_data);
// the other, rsp, returns one result per access: rom_hit, the program ROM
// byte offset of a read, and the mirroring bit after the access.
// Each access is captured in an input register, decoded and mapped through
// the bank registers by a short mux path, and lands in a result register.
// A result is offered on rsp once its access has passed from the input
// register into the result register, which waits while rsp stalls.
// Throughput is one access per cycle while rsp is not stalled; the bank
// register file is updated as an access moves into the result register,
// so a read right after a write already sees the new bank value.
// When the receiver stalls with a result waiting, an empty input register
// still takes one more access; req.ready is low until rsp takes its transfer.
// Reset clears all bank registers and the mirroring bit to zero and empties
// both pipeline registers.
module nibble_loaded_bank_mapper (
	input  logic        clk,
	input  logic        arst_n,
	nlbm_req_if.sink    req,
	nlbm_rsp_if.source  rsp
);
	import nlbm_pkg::*;

	logic              valid_s1;
	logic              req_type_s1;
	logic [ADDR_W-1:0] bus_addr_s1;
	logic [DATA_W-1:0] write_data_s1;

	logic              valid_s2;
	logic              rom_hit_s2;
	logic [OFF_W-1:0]  rom_offset_s2;
	logic              mirror_s2;

	logic                  stall;
	logic                  advance;
	wr_req_t               wr;
	logic [BANK_IDX_W-1:0] rd_idx;
	logic [BANK_W-1:0]     rd_bank;
	logic                  mirror_next;
	logic                  hit;
	logic [OFF_W-1:0]      offset;

	// Pipeline flow control.
	assign stall     = valid_s2 && !rsp.ready;
	assign advance   = valid_s1 && !stall;
	assign req.ready = !valid_s1 || !stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1   <= req.req_type;
			bus_addr_s1   <= req.bus_addr;
			write_data_s1 <= req.write_data;
		end
	end

	// Write request toward the register file, issued as the access advances.
	always_comb begin
		wr.en   = advance && (req_type_s1 == REQ_WRITE);
		wr.top  = bus_addr_s1[15:12];
		wr.sel  = bus_addr_s1[1:0];
		wr.data = write_data_s1;
	end

	// Windows at 0x6000 use registers 4 to 7, windows at 0x8000 use 0 to 3.
	assign rd_idx = {~bus_addr_s1[15], bus_addr_s1[12:11]};

	nlbm_bank_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.rd_idx      (rd_idx),
		.rd_bank     (rd_bank),
		.mirror_next (mirror_next)
	);

	// Read address translation, wrapped to the ROM size.
	always_comb begin
		hit    = (req_type_s1 == REQ_READ) && (bus_addr_s1 >= ROM_BASE);
		offset = '0;
		if (hit) begin
			if (bus_addr_s1 < FIXED8K_LO) begin
				offset = {rd_bank, bus_addr_s1[10:0]};
			end else if (bus_addr_s1 < FIXED16K_LO) begin
				offset = {FIXED8K_BANK, bus_addr_s1[12:0]};
			end else begin
				offset = {FIXED16K_BANK, bus_addr_s1[13:0]};
			end
			offset = offset & ROM_MASK;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rom_hit_s2    <= hit;
			rom_offset_s2 <= offset;
			mirror_s2     <= mirror_next;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.rom_hit       = rom_hit_s2;
	assign rsp.rom_offset    = rom_offset_s2;
	assign rsp.mirror_select = mirror_s2;

endmodule
